/* hdl/cal_pkg.sv */
// cal_pkg: shared codes and types for the compacting array list
// holds operation codes, status codes and the sequencer state type
// no dependencies
`default_nettype none

package cal_pkg;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_RANGE     = 2'd3;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_SHIFT = 6'b001000,
        S_RDATA = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

endpackage

`default_nettype wire

/* hdl/cal_ram.sv */
// cal_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module cal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                                  clk,
    input  wire logic                                  wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/compacting_array_list.sv */
// compacting_array_list: ordered list of 32-bit values with append, remove and read
// depends on cal_pkg and cal_ram
//
// usage: one command word enters on the s_axis group, one result word leaves on
// the m_axis group. a word is taken when tvalid and tready are both high.
// s_tready is high only while the sequencer is idle; one command is worked on at
// a time, and the next may be taken while the previous result still waits.
// path from an accepted command to m_tvalid:
//   append, out-of-range read, unused opcode: exec, then done
//   in-range read: exec, one registered ram read, then done
//   remove: exec, a search, then on a match a compaction, then done; the
//   search and the compaction each move one entry per cycle through the
//   single ram read port
// the next command may be taken in the cycle after the result register is loaded
// every entry goes through one ram with one write and one read port and a
// single 32-bit compare.
// reset clears the count and the handshake state; the ram needs no clearing,
// since only entries below the count are ever read.
// when the receiver stalls, the result is held in the output register and the
// sequencer waits in its final state before returning to idle.
`default_nettype none

module compacting_array_list #(
    parameter int CAPACITY = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // value[31:0], position[39:32]
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // read_data[31:0], entry_count[39:32]
    output logic      [1:0]  m_tuser    // status[1:0]
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = (CW > 8) ? CW : 8;

    cal_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          have_reg, have_next;
    logic [1:0]    op_reg, op_next;
    logic [31:0]   val_reg, val_next;
    logic [7:0]    pos_reg, pos_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [31:0]   res_data_reg, res_data_next;

    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_status_reg, out_status_next;
    logic [31:0]   out_data_reg, out_data_next;
    logic [7:0]    out_count_reg, out_count_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;

    logic          s_accept;
    logic          pos_in_range;
    logic          ptr_more;

    cal_ram #(
        .WIDTH(32),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign s_tready = (state_reg == cal_pkg::S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign pos_in_range = (WW'(pos_reg) < WW'(count_reg)) && (WW'(pos_reg) < WW'(CAPACITY));
    assign ptr_more = (ptr_reg < count_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_data_reg};
    assign m_tuser  = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        have_next       = have_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_count_next  = out_count_reg;
        wr_en           = 1'b0;
        wr_addr         = AW'(count_reg);
        wr_data         = val_reg;
        rd_en           = 1'b0;
        rd_addr         = AW'(ptr_reg);

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            cal_pkg::S_IDLE:
            begin
                if (s_accept)
                begin
                    op_next         = s_tuser;
                    val_next        = s_tdata[31:0];
                    pos_next        = s_tdata[39:32];
                    res_status_next = cal_pkg::STAT_OK;
                    res_data_next   = '0;
                    state_next      = cal_pkg::S_EXEC;
                end
            end
            cal_pkg::S_EXEC:
            begin
                case (op_reg)
                    cal_pkg::OP_APPEND:
                    begin
                        if (count_reg < CW'(CAPACITY))
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            res_status_next = cal_pkg::STAT_FULL;
                        end
                        state_next = cal_pkg::S_DONE;
                    end
                    cal_pkg::OP_REMOVE:
                    begin
                        ptr_next   = '0;
                        have_next  = 1'b0;
                        state_next = cal_pkg::S_SCAN;
                    end
                    cal_pkg::OP_READ:
                    begin
                        if (pos_in_range)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(pos_reg);
                            state_next = cal_pkg::S_RDATA;
                        end
                        else
                        begin
                            res_status_next = cal_pkg::STAT_RANGE;
                            res_data_next   = '1;
                            state_next      = cal_pkg::S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = cal_pkg::S_DONE;
                    end
                endcase
            end
            cal_pkg::S_SCAN:
            begin
                rd_en     = ptr_more;
                have_next = ptr_more;
                if (ptr_more)
                begin
                    ptr_next = ptr_reg + CW'(1);
                end
                if (have_reg && (rd_data == val_reg))
                begin
                    state_next = cal_pkg::S_SHIFT;
                end
                else if (!ptr_more)
                begin
                    res_status_next = cal_pkg::STAT_NOT_FOUND;
                    state_next      = cal_pkg::S_DONE;
                end
            end
            cal_pkg::S_SHIFT:
            begin
                if (have_reg)
                begin
                    // move the entry just read one place down
                    wr_en     = 1'b1;
                    wr_addr   = AW'(ptr_reg - CW'(2));
                    wr_data   = rd_data;
                    rd_en     = ptr_more;
                    have_next = ptr_more;
                    if (ptr_more)
                    begin
                        ptr_next = ptr_reg + CW'(1);
                    end
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = cal_pkg::S_DONE;
                end
            end
            cal_pkg::S_RDATA:
            begin
                res_data_next = rd_data;
                state_next    = cal_pkg::S_DONE;
            end
            cal_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_data_next   = res_data_reg;
                    out_count_next  = 8'(count_reg);
                    state_next      = cal_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cal_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cal_pkg::S_IDLE;
            count_reg     <= '0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        op_reg         <= op_next;
        val_reg        <= val_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_count_reg  <= out_count_next;
    end

    // count stays within capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // compaction always writes behind the read pointer
    a_shift_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cal_pkg::S_SHIFT) && have_reg |-> ptr_reg >= CW'(2))
        else $error("shift write address underflow");

    // a full report only happens with a full list
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cal_pkg::S_DONE) && (res_status_reg == cal_pkg::STAT_FULL)
        |-> count_reg == CW'(CAPACITY))
        else $error("full status with free room");

    // an accepted command is started in the next cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> state_reg == cal_pkg::S_EXEC)
        else $error("accepted command not started");

endmodule

`default_nettype wire
